[rtl/qdv_pkg.sv]
// ----------------------------------------------------------------------------
// qdv_pkg
// Shared constants for the quadrature decoder with period-based velocity.
// ----------------------------------------------------------------------------
package qdv_pkg;

  localparam int unsigned SCALE_W   = 40;
  localparam int unsigned LIMIT_W   = 32;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned S_DATA_W  = 40;
  localparam int unsigned M_DATA_W  = 2 * OUT_W;

  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE   = CFG_IDX_W'(1);

  localparam logic [MODE_W-1:0] MODE_SAMPLE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_EDGE_A = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_EDGE_B = MODE_W'(2);

  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = LIMIT_W'(100000);
  localparam logic [SCALE_W-1:0] VEL_SCALE_RST   = SCALE_W'(65536);

  localparam logic [OUT_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] VEL_MIN = 32'h8000_0000;

endpackage

[rtl/quadrature_decoder_with_velocity.sv]
// ----------------------------------------------------------------------------
// quadrature_decoder_with_velocity
// x4 quadrature decoder for one axis with edge-period velocity.
// ----------------------------------------------------------------------------
// One item in, one item out. A plain sample skips the divider and goes from
// the input to the output register. For an edge item whose interval since the
// previous edge is nonzero, the velocity quotient velocity_scale / interval
// comes from a radix-2 restoring divider that retires one quotient bit per
// cycle over the 40-bit scale; such an item is taken, divided, saturated and
// loaded into the output register. A new item is taken while a finished item
// still waits on the output side. A plain sample whose time since the last
// edge exceeds stale_limit_us reads velocity zero and tuser flags stale.
module quadrature_decoder_with_velocity
  import qdv_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCALE_W-1:0]   cfg_data_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] line_a, [1] line_b, [33:2] now_us, [39:34] zero
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [MODE_W-1:0]    s_axis_tuser,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] position_ticks, [63:32] velocity
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  // [0] stale
  output logic                 m_axis_tuser
);

  localparam int unsigned CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;
  localparam int unsigned CNT_W = $clog2(SCALE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCALE_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_VEL,
    ST_FIN
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [LIMIT_W-1:0]     stale_limit_q;
  logic [SCALE_W-1:0]     vel_scale_q;
  logic [COUNT_WIDTH-1:0] tick_count_q;
  logic [TIME_WIDTH-1:0]  last_edge_q;
  logic [OUT_W-1:0]       held_vel_q;
  logic                   m_valid_q;

  logic [TIME_WIDTH-1:0]  dt_q;
  logic [SCALE_W-1:0]     div_q;
  logic [TIME_WIDTH-1:0]  rem_q;
  logic                   down_q;
  logic                   stale_q;
  logic [M_DATA_W-1:0]    m_data_q;
  logic                   m_user_q;

  logic                   in_acc;
  logic                   out_load;
  logic                   is_edge;
  logic                   down_d;
  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  dt_d;
  logic                   stale_d;
  logic [TIME_WIDTH:0]    rem_sh;
  logic                   q_bit;
  logic [TIME_WIDTH-1:0]  rem_d;
  logic [SCALE_W-1:0]     div_d;
  logic [OUT_W-1:0]       vel_sat;
  logic [OUT_W-1:0]       pos_out;
  logic [OUT_W-1:0]       vel_out;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  assign is_edge = (s_axis_tuser == MODE_EDGE_A) || (s_axis_tuser == MODE_EDGE_B);
  assign down_d  = (s_axis_tuser == MODE_EDGE_A) ? (s_axis_tdata[0] == s_axis_tdata[1])
                                                 : (s_axis_tdata[0] != s_axis_tdata[1]);
  assign now_t   = TIME_WIDTH'(s_axis_tdata[33:2]);
  assign dt_d    = now_t - last_edge_q;
  assign stale_d = !is_edge && (CMP_W'(dt_d) > CMP_W'(stale_limit_q));

  assign rem_sh = {rem_q, div_q[SCALE_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dt_q});
  assign rem_d  = q_bit ? TIME_WIDTH'(rem_sh - {1'b0, dt_q}) : rem_sh[TIME_WIDTH-1:0];
  assign div_d  = {div_q[SCALE_W-2:0], q_bit};

  always_comb begin
    if (down_q) begin
      if ((|div_q[SCALE_W-1:OUT_W]) || (div_q[OUT_W-1] && (|div_q[OUT_W-2:0]))) begin
        vel_sat = VEL_MIN;
      end else begin
        vel_sat = (~div_q[OUT_W-1:0]) + OUT_W'(1);
      end
    end else begin
      vel_sat = (|div_q[SCALE_W-1:OUT_W-1]) ? VEL_MAX : div_q[OUT_W-1:0];
    end
  end

  assign pos_out = OUT_W'(signed'(tick_count_q));
  assign vel_out = stale_q ? '0 : held_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      stale_limit_q <= STALE_LIMIT_RST;
      vel_scale_q   <= VEL_SCALE_RST;
      tick_count_q  <= '0;
      last_edge_q   <= '0;
      held_vel_q    <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
      m_user_q      <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_STALE_LIMIT)) begin
        stale_limit_q <= cfg_data_i[LIMIT_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == REG_VEL_SCALE)) begin
        vel_scale_q <= cfg_data_i;
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {vel_out, pos_out};
        m_user_q  <= stale_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_q   <= '0;
            state_q <= ST_FIN;
            if (is_edge) begin
              tick_count_q <= down_d ? tick_count_q - COUNT_WIDTH'(1)
                                     : tick_count_q + COUNT_WIDTH'(1);
              last_edge_q  <= now_t;
              if (dt_d != '0) begin
                state_q <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_VEL;
          end
        end
        ST_VEL: begin
          held_vel_q <= vel_sat;
          state_q    <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q    <= dt_d;
      div_q   <= vel_scale_q;
      rem_q   <= '0;
      down_q  <= down_d;
      stale_q <= stale_d;
    end else if (state_q == ST_DIV) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[rtl/qdv_checker.sv]
// ----------------------------------------------------------------------------
// qdv_checker
// Port-level checks for the quadrature decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qdv_checker
  import qdv_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready stayed high after an item was taken");

  a_stale_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[M_DATA_W-1:OUT_W] == '0))
    else $error("stale item carries a nonzero velocity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output item changed or dropped");

  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output item appeared while the block was idle");

endmodule

bind quadrature_decoder_with_velocity qdv_checker u_qdv_checker (.*);
